>>> hdl/flfd_pkg.sv
// Shared types and constants for the fixed-length frame deframer.
package flfd_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'hFF;

    typedef enum logic {
        CFG_START_MARKER = 1'b0,
        CFG_END_MARKER   = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_START2 = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_END1   = 5'b01000,
        PH_END2   = 5'b10000
    } t_phase;

endpackage

>>> hdl/flfd_store.sv
// Payload store: one write port, one read port with registered read data.
module flfd_store #(
    parameter int DEPTH = 28,
    parameter int AW    = 5
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [flfd_pkg::BYTE_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [flfd_pkg::BYTE_W-1:0] o_rd_data
);

    logic [flfd_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [flfd_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/flfd_emit.sv
// Payload emitter: walks the store and drives the output register.
module flfd_emit #(
    parameter int LEN = 28,
    parameter int AW  = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr,
    input  logic [flfd_pkg::BYTE_W-1:0] i_rd_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [flfd_pkg::BYTE_W-1:0] o_payload_byte,
    output logic [flfd_pkg::POS_W-1:0]  o_payload_pos,
    output logic                        o_last_of_frame
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(LEN - 1);

    logic                        r_active, n_active;
    logic [AW-1:0]               r_rd_addr, n_rd_addr;
    logic                        r_pend, n_pend;
    logic [AW-1:0]               r_pend_addr;
    logic                        r_out_valid, n_out_valid;
    logic [flfd_pkg::BYTE_W-1:0] r_out_byte;
    logic [AW-1:0]               r_out_addr;
    logic                        w_load;
    logic                        w_issue;

    // Move read data into the output register when the slot is free.
    assign w_load  = r_pend && (!r_out_valid || !i_stall);
    // Issue the next read once the pending one has somewhere to go.
    assign w_issue = r_active && (!r_pend || w_load);

    always_comb begin
        n_active  = r_active;
        n_rd_addr = r_rd_addr;
        if (i_start) begin
            n_active  = 1'b1;
            n_rd_addr = '0;
        end else if (w_issue) begin
            n_rd_addr = r_rd_addr + 1'b1;
            if (r_rd_addr == LAST_ADDR) begin
                n_active = 1'b0;
            end
        end

        if (w_issue) begin
            n_pend = 1'b1;
        end else if (w_load) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_rd_addr   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_rd_addr   <= n_rd_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_pend_addr <= r_rd_addr;
        end
        if (w_load) begin
            r_out_byte <= i_rd_data;
            r_out_addr <= r_pend_addr;
        end
    end

    assign o_busy          = r_active || r_pend;
    assign o_rd_en         = w_issue;
    assign o_rd_addr       = r_rd_addr;
    assign o_valid         = r_out_valid;
    assign o_payload_byte  = r_out_byte;
    assign o_payload_pos   = flfd_pkg::POS_W'(r_out_addr);
    assign o_last_of_frame = (r_out_addr == LAST_ADDR);

endmodule

>>> hdl/fixed_length_frame_deframer.sv
// Top level: frame hunt and capture, payload store and emitter.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------------------
//  rx in    | i_rx_valid   | o_rx_stall   | i_rx_byte
//  frame out| o_pl_valid   | i_pl_stall   | o_payload_byte, o_payload_pos, o_last_of_frame
//
// One received byte is taken per cycle while the emitter is idle.
// A completed frame streams FRAME_BYTES-4 bytes at up to one per cycle, one
// read of the store port per byte; the rx side stalls for that run,
// which any output stall lengthens.
// Reset (synchronous, active low) returns to hunting and restores the markers.
// The last payload byte may wait in the output register while rx bytes flow.
module fixed_length_frame_deframer #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [flfd_pkg::BYTE_W-1:0] i_cfg_wdata,
    input  logic                        i_rx_valid,
    output logic                        o_rx_stall,
    input  logic [flfd_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_pl_valid,
    input  logic                        i_pl_stall,
    output logic [flfd_pkg::BYTE_W-1:0] o_payload_byte,
    output logic [flfd_pkg::POS_W-1:0]  o_payload_pos,
    output logic                        o_last_of_frame
);

    localparam int LEN = FRAME_BYTES - 4;
    localparam int AW  = (LEN > 1) ? $clog2(LEN) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(LEN - 1);

    logic [flfd_pkg::BYTE_W-1:0] r_start_marker;
    logic [flfd_pkg::BYTE_W-1:0] r_end_marker;
    flfd_pkg::t_phase            r_phase, n_phase;
    logic [AW-1:0]               r_fill, n_fill;
    logic                        w_accept;
    logic                        w_start_hit;
    logic                        w_end_hit;
    logic                        w_wr_en;
    logic                        w_emit_start;
    logic                        w_busy;
    logic                        w_rd_en;
    logic [AW-1:0]               w_rd_addr;
    logic [flfd_pkg::BYTE_W-1:0] w_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= flfd_pkg::START_MARKER_RST;
            r_end_marker   <= flfd_pkg::END_MARKER_RST;
        end else if (i_cfg_we) begin
            unique case (flfd_pkg::t_cfg_idx'(i_cfg_idx))
                flfd_pkg::CFG_START_MARKER: r_start_marker <= i_cfg_wdata;
                flfd_pkg::CFG_END_MARKER:   r_end_marker   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_rx_stall  = w_busy;
    assign w_accept    = i_rx_valid && !o_rx_stall;
    assign w_start_hit = (i_rx_byte == r_start_marker);
    assign w_end_hit   = (i_rx_byte == r_end_marker);

    always_comb begin
        n_phase      = r_phase;
        n_fill       = r_fill;
        w_wr_en      = 1'b0;
        w_emit_start = 1'b0;
        if (w_accept) begin
            unique case (r_phase)
                flfd_pkg::PH_START2: begin
                    n_phase = w_start_hit ? flfd_pkg::PH_DATA : flfd_pkg::PH_HUNT;
                    n_fill  = '0;
                end
                flfd_pkg::PH_DATA: begin
                    w_wr_en = 1'b1;
                    n_fill  = r_fill + 1'b1;
                    if (r_fill == LAST_ADDR) begin
                        n_phase = flfd_pkg::PH_END1;
                    end
                end
                flfd_pkg::PH_END1: begin
                    n_phase = w_end_hit ? flfd_pkg::PH_END2 : flfd_pkg::PH_HUNT;
                end
                flfd_pkg::PH_END2: begin
                    w_emit_start = w_end_hit;
                    n_phase      = flfd_pkg::PH_HUNT;
                end
                default: begin
                    // hunting, and any unused code acts as hunting
                    n_phase = w_start_hit ? flfd_pkg::PH_START2 : flfd_pkg::PH_HUNT;
                    n_fill  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= flfd_pkg::PH_HUNT;
            r_fill  <= '0;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
        end
    end

    flfd_store #(
        .DEPTH (LEN),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_fill),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    flfd_emit #(
        .LEN (LEN),
        .AW  (AW)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_emit_start),
        .o_busy          (w_busy),
        .o_rd_en         (w_rd_en),
        .o_rd_addr       (w_rd_addr),
        .i_rd_data       (w_rd_data),
        .o_valid         (o_pl_valid),
        .i_stall         (i_pl_stall),
        .o_payload_byte  (o_payload_byte),
        .o_payload_pos   (o_payload_pos),
        .o_last_of_frame (o_last_of_frame)
    );

`ifndef NO_ASSERTIONS
    a_no_write_during_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> !w_busy)
        else $error("store written while payload is being read out");

    a_start_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_start |-> (!w_busy && r_phase == flfd_pkg::PH_END2))
        else $error("emit started outside second end marker or while busy");

    a_stall_after_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_start |=> (o_rx_stall && w_rd_en && w_rd_addr == '0))
        else $error("emitter did not begin at the first payload entry");
`endif

endmodule

>>> tb/fixed_length_frame_deframer_checker.sv
// Checker for the frame deframer: predicts payload runs from the rx stream and compares them.
module fixed_length_frame_deframer_checker
    import flfd_pkg::*;
#(
    parameter int FRAME_BYTES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [BYTE_W-1:0] i_cfg_wdata,
    input  logic              i_rx_valid,
    input  logic              i_rx_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_pl_valid,
    input  logic              i_pl_stall,
    input  logic [BYTE_W-1:0] i_payload_byte,
    input  logic [POS_W-1:0]  i_payload_pos,
    input  logic              i_last_of_frame,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int PAYLOAD_LEN = FRAME_BYTES - 4;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_payload_out;

    t_payload_out      payload_due[$];
    t_payload_out      want;
    logic [BYTE_W-1:0] start_mark;
    logic [BYTE_W-1:0] end_mark;
    t_phase            rx_phase;
    logic [6:0]        stored;
    logic [BYTE_W-1:0] frame_store [PAYLOAD_LEN];
    int                errors = 0;

    // Advance the frame tracker by one received byte; queue the payload run on a good end.
    task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b);
        t_payload_out r;
        int           k;
        case (rx_phase)
            PH_START2: begin
                if (b == start_mark) begin
                    stored   = '0;
                    rx_phase = PH_DATA;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                if (stored < PAYLOAD_LEN)
                    frame_store[stored] = b;
                stored = stored + 7'd1;
                if (stored >= PAYLOAD_LEN)
                    rx_phase = PH_END1;
            end
            PH_END1: begin
                rx_phase = (b == end_mark) ? PH_END2 : PH_HUNT;
            end
            PH_END2: begin
                if (b == end_mark) begin
                    for (k = 0; k < PAYLOAD_LEN; k++) begin
                        r.data = frame_store[k];
                        r.pos  = POS_W'(k);
                        r.last = (k == PAYLOAD_LEN - 1);
                        payload_due.push_back(r);
                    end
                end
                rx_phase = PH_HUNT;
            end
            default: begin
                if (b == start_mark) begin
                    stored   = '0;
                    rx_phase = PH_START2;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_mark = START_MARKER_RST;
            end_mark   = END_MARKER_RST;
            rx_phase   = PH_HUNT;
            stored     = '0;
            payload_due.delete();
        end else begin
            if (i_pl_valid && !i_pl_stall) begin
                if (payload_due.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected payload transaction byte %02h pos %0d last %0b",
                             $time, i_payload_byte, i_payload_pos, i_last_of_frame);
                end else begin
                    want = payload_due.pop_front();
                    if (i_payload_byte !== want.data) begin
                        errors = errors + 1;
                        $display("%0t: payload_byte expected %02h actual %02h",
                                 $time, want.data, i_payload_byte);
                    end
                    if (i_payload_pos !== want.pos) begin
                        errors = errors + 1;
                        $display("%0t: payload_pos expected %0d actual %0d",
                                 $time, want.pos, i_payload_pos);
                    end
                    if (i_last_of_frame !== want.last) begin
                        errors = errors + 1;
                        $display("%0t: last_of_frame expected %0b actual %0b",
                                 $time, want.last, i_last_of_frame);
                    end
                end
            end
            if (i_rx_valid && !i_rx_stall)
                absorb_rx_byte(i_rx_byte);
            // Marker writes apply from the next byte on.
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_START_MARKER)
                    start_mark = i_cfg_wdata;
                else
                    end_mark = i_cfg_wdata;
            end
        end
        o_pending    <= payload_due.size();
        o_fail_count <= errors;
    end

endmodule

>>> tb/fixed_length_frame_deframer_test.sv
// Testbench top for the frame deframer: clock, reset, rx stimulus, output stalls and verdict.
module fixed_length_frame_deframer_test;
    import flfd_pkg::*;

    localparam int FRAME_BYTES     = 32;
    localparam int PAYLOAD_LEN     = FRAME_BYTES - 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 90;
    localparam int DRAIN_CYCLES    = FRAME_BYTES + 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [BYTE_W-1:0] i_cfg_wdata;
    logic              i_rx_valid;
    logic [BYTE_W-1:0] i_rx_byte;
    logic              i_pl_stall = 1'b0;
    logic              o_rx_stall;
    logic              o_pl_valid;
    logic [BYTE_W-1:0] o_payload_byte;
    logic [POS_W-1:0]  o_payload_pos;
    logic              o_last_of_frame;

    int                fail_count;
    int                pending;
    bit                gaps_on = 1'b1;
    int                hold_seq = 0;
    int                hold_seen = 0;
    int                hold_left = 0;
    int                rx_sent = 0;
    logic [BYTE_W-1:0] start_mark;
    logic [BYTE_W-1:0] end_mark;

    always #6 i_clk = ~i_clk;

    fixed_length_frame_deframer #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_pl_valid     (o_pl_valid),
        .i_pl_stall     (i_pl_stall),
        .o_payload_byte (o_payload_byte),
        .o_payload_pos  (o_payload_pos),
        .o_last_of_frame(o_last_of_frame)
    );

    fixed_length_frame_deframer_checker #(
        .FRAME_BYTES(FRAME_BYTES)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_rx_valid     (i_rx_valid),
        .i_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .i_pl_valid     (o_pl_valid),
        .i_pl_stall     (i_pl_stall),
        .i_payload_byte (o_payload_byte),
        .i_payload_pos  (o_payload_pos),
        .i_last_of_frame(o_last_of_frame),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Output side: a requested hold-off wins over random stalls.
    always begin
        @(negedge i_clk);
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_pl_stall <= 1'b1;
        end else begin
            i_pl_stall <= gaps_on && ($urandom_range(99) < 24);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // Offer one byte and hold it until the transaction completes.
    task automatic send_rx(input logic [BYTE_W-1:0] b);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 24) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do
            @(posedge i_clk);
        while (o_rx_stall);
        rx_sent = rx_sent + 1;
    endtask

    // Drop valid and wait until every queued payload byte has been taken.
    task automatic drain_frames(input int extra);
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
        drain_frames(4);
        write_reg(CFG_START_MARKER, s);
        write_reg(CFG_END_MARKER, e);
        start_mark = s;
        end_mark   = e;
    endtask

    function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] x);
        return x ^ BYTE_W'($urandom_range(1, 255));
    endfunction

    task automatic send_frame(input logic [BYTE_W-1:0] st2, input logic [BYTE_W-1:0] en1,
                              input logic [BYTE_W-1:0] en2, input bit walking);
        logic [BYTE_W-1:0] b;
        int                k;
        send_rx(start_mark);
        send_rx(st2);
        for (k = 0; k < PAYLOAD_LEN; k++) begin
            if (walking) begin
                case (k)
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    2:       b = start_mark;
                    3:       b = end_mark;
                    default: b = (8'h01 << (k % 8)) ^ (((k / 8) % 2) ? 8'hFF : 8'h00);
                endcase
            end else begin
                case ($urandom_range(15))
                    0:       b = start_mark;
                    1:       b = end_mark;
                    default: b = BYTE_W'($urandom);
                endcase
            end
            send_rx(b);
        end
        send_rx(en1);
        send_rx(en2);
    endtask

    // Mostly well-formed frames with random content, the rest broken frames and line noise.
    task automatic random_traffic(input int count);
        int target;
        int pick;
        target = rx_sent + count;
        while (rx_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_frame(start_mark, end_mark, end_mark, 1'b0);
            else if (pick < 70)
                send_frame(start_mark, other_than(end_mark), end_mark, 1'b0);
            else if (pick < 80)
                send_frame(start_mark, end_mark, other_than(end_mark), 1'b0);
            else if (pick < 90) begin
                send_rx(start_mark);
                send_rx(other_than(start_mark));
            end else begin
                repeat ($urandom_range(1, 5)) send_rx(BYTE_W'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_START_MARKER;
        i_cfg_wdata = '0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = '0;
        start_mark  = START_MARKER_RST;
        end_mark    = END_MARKER_RST;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_markers(START_MARKER_RST, END_MARKER_RST);
        send_rx(8'h00);
        send_rx(8'hFF);
        send_frame(start_mark, end_mark, end_mark, 1'b1);
        // wrong second start byte
        send_rx(start_mark);
        send_rx(other_than(start_mark));
        // wrong first end byte
        send_frame(start_mark, other_than(end_mark), end_mark, 1'b1);
        // wrong second end byte that looks like a start marker must not open a frame
        send_frame(start_mark, end_mark, start_mark, 1'b0);
        send_frame(start_mark, end_mark, end_mark, 1'b0);

        set_markers(8'h00, 8'hFF);
        random_traffic(8);

        // No idling; hold the output long enough for the rx side to back up.
        set_markers(8'hFF, 8'h00);
        gaps_on  = 1'b0;
        hold_seq = hold_seq + 1;
        send_frame(start_mark, end_mark, end_mark, 1'b0);
        send_frame(start_mark, end_mark, end_mark, 1'b0);
        gaps_on = 1'b1;

        set_markers(8'h5A, 8'h5A);
        random_traffic(8);

        set_markers(BYTE_W'($urandom), BYTE_W'($urandom));
        random_traffic(8);

        drain_frames(DRAIN_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
hdl/flfd_pkg.sv
hdl/flfd_store.sv
hdl/flfd_emit.sv
hdl/fixed_length_frame_deframer.sv
tb/fixed_length_frame_deframer_checker.sv
tb/fixed_length_frame_deframer_test.sv
